FILE: sv/b64le_pkg.sv
// Shared types, constants and the symbol table of the base64 line encoder.
package b64le_pkg;

    localparam int LINE_CHARS_DEFAULT = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [2:0] SLOT_NEWLINE = 3'd4;
    localparam logic [2:0] SLOT_LAST_SYMBOL = 3'd3;

    typedef struct packed {
        logic [3:0][5:0] sextet;
        logic [2:0]      num_symbols;
        logic            last;
    } group_rec_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

    function automatic logic [7:0] sym_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26)
        begin
            c = 8'h41 + {2'b00, s};
        end
        else if (s < 6'd52)
        begin
            c = 8'h61 + {2'b00, s} - 8'd26;
        end
        else if (s < 6'd62)
        begin
            c = 8'h30 + {2'b00, s} - 8'd52;
        end
        else if (s == 6'd62)
        begin
            c = 8'h2B;
        end
        else
        begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

FILE: sv/b64le_front.sv
// Front part: gathers bytes into three-byte groups and splits each group into sextets.
module b64le_front
    import b64le_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       is_last,
    output logic       rec_push,
    output group_rec_t rec
);

    logic [15:0] pending_reg;
    logic [15:0] pending_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic        closes_group;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;

    assign closes_group = (phase_reg == 2'd2) || is_last;
    assign rec_push = accept && closes_group;

    always_comb
    begin
        pending_next = pending_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            if (closes_group)
            begin
                pending_next = 16'h0000;
                phase_next = 2'd0;
            end
            else if (phase_reg == 2'd0)
            begin
                pending_next = {data_byte, 8'h00};
                phase_next = 2'd1;
            end
            else
            begin
                pending_next = {pending_reg[15:8], data_byte};
                phase_next = 2'd2;
            end
        end
    end

    always_comb
    begin
        b0 = (phase_reg == 2'd0) ? data_byte : pending_reg[15:8];
        b1 = (phase_reg == 2'd0) ? 8'h00 :
             ((phase_reg == 2'd1) ? data_byte : pending_reg[7:0]);
        b2 = (phase_reg == 2'd2) ? data_byte : 8'h00;
        rec.sextet[0] = b0[7:2];
        rec.sextet[1] = {b0[1:0], b1[7:4]};
        rec.sextet[2] = {b1[3:0], b2[7:6]};
        rec.sextet[3] = b2[5:0];
        rec.num_symbols = {1'b0, phase_reg} + 3'd2;
        rec.last = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 16'h0000;
            phase_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: sv/b64le_queue.sv
// Short queue of group records between the front and back parts.
module b64le_queue
    import b64le_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  group_rec_t    push_rec,
    input  logic          pop,
    output group_rec_t    head_rec,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_rec_t         mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full = (count_reg == CNT_W'(DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign do_push = push && !status.full;
    assign do_pop = pop && status.not_empty;
    assign head_rec = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: sv/b64le_back.sv
// Back part: walks each group record out as characters, with line breaks and padding.
module b64le_back
    import b64le_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  group_rec_t    head_rec,
    input  queue_status_t q_status,
    output logic          rec_pop,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    out_char,
    output logic          run_last
);

    localparam int LINE_GROUPS = (LINE_CHARS / 4 < 1) ? 1 : LINE_CHARS / 4;
    localparam int COL_W = (LINE_GROUPS > 1) ? $clog2(LINE_GROUPS) : 1;

    logic [2:0]       slot_reg;
    logic [2:0]       slot_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_char_reg;
    logic [7:0]       out_char_next;
    logic             run_last_reg;
    logic             run_last_next;
    logic             emit;
    logic             need_newline;
    logic             final_slot;
    logic [7:0]       slot_char;

    assign emit = q_status.not_empty && (!out_valid_reg || pop);
    assign need_newline = head_rec.last || (col_reg == COL_W'(LINE_GROUPS - 1));
    assign final_slot = (slot_reg == SLOT_NEWLINE) ||
                        ((slot_reg == SLOT_LAST_SYMBOL) && !need_newline);
    assign rec_pop = emit && final_slot;

    always_comb
    begin
        if (slot_reg == SLOT_NEWLINE)
        begin
            slot_char = CHAR_NEWLINE;
        end
        else if (slot_reg < head_rec.num_symbols)
        begin
            slot_char = sym_char(head_rec.sextet[slot_reg[1:0]]);
        end
        else
        begin
            slot_char = CHAR_PAD;
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        col_next = col_reg;
        out_valid_next = out_valid_reg;
        out_char_next = out_char_reg;
        run_last_next = run_last_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next = slot_char;
            run_last_next = final_slot;
            if (final_slot)
            begin
                slot_next = 3'd0;
                col_next = need_newline ? '0 : col_reg + 1'b1;
            end
            else
            begin
                slot_next = slot_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 3'd0;
            col_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            col_reg <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        run_last_reg <= run_last_next;
    end

    assign empty = !out_valid_reg;
    assign out_char = out_char_reg;
    assign run_last = run_last_reg;

endmodule

FILE: sv/base64_line_encoder_unit.sv
// Top level of the base64 line encoder: joins the front part, the group queue and the back part.
// Bytes enter one per cycle while the queue is not full; each byte that closes a three-byte
// group, or carries the last flag, sends a group record through a two-entry queue to the back
// part, which sends one character per cycle while the output is popped: four symbols, then a
// newline when the line is full or the stream ends. A three-byte group thus gives four or five
// characters on the one-character output port. A result waits in an output register while new
// beats enter.
module base64_line_encoder_unit
    import b64le_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       is_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       run_last
);

    group_rec_t    front_rec;
    group_rec_t    head_rec;
    queue_status_t q_status;
    logic          rec_push;
    logic          rec_pop;
    logic          accept;

    assign full = q_status.full;
    assign accept = push && !full;

    b64le_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .is_last   (is_last),
        .rec_push  (rec_push),
        .rec       (front_rec)
    );

    b64le_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (rec_push),
        .push_rec (front_rec),
        .pop      (rec_pop),
        .head_rec (head_rec),
        .status   (q_status)
    );

    b64le_back #(
        .LINE_CHARS (LINE_CHARS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_rec (head_rec),
        .q_status (q_status),
        .rec_pop  (rec_pop),
        .pop      (pop),
        .empty    (empty),
        .out_char (out_char),
        .run_last (run_last)
    );

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(rec_push && q_status.full))
        else $error("group record pushed into a full queue");

    a_queue_feeds_output: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.not_empty && empty) |=> !empty)
        else $error("waiting group record did not reach the output register");

    a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !run_last) |=> !empty)
        else $error("character stream of a group broke off before its last beat");
`endif

endmodule

FILE: test/b64_stream_checker.sv
// Checker that predicts the base64 text of the accepted byte stream and compares every output beat.
`timescale 1ns / 1ps

module b64_stream_checker
    import b64le_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] data_byte,
    input  logic       is_last,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] out_char,
    input  logic       run_last,
    output int         mismatches,
    output int         backlog
);

    localparam int WRAP_WIDTH = ((LINE_CHARS / 4) * 4 < 4) ? 4 : (LINE_CHARS / 4) * 4;
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    char_beat_t  expected_chars[$];
    logic [15:0] held_bytes;
    logic [1:0]  group_fill;
    int          column;
    int          beat_index;

    function automatic logic [7:0] symbol(input logic [5:0] s);
        int idx;
        idx = 63 - int'(s);
        return ALPHABET[8*idx +: 8];
    endfunction

    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] syms [0:3];
        logic [7:0] chars [0:4];
        int         held;
        int         n;
        char_beat_t beat;
        if (group_fill < 2'd2 && !last)
        begin
            if (group_fill == 2'd0)
            begin
                held_bytes = {b, 8'h00};
            end
            else
            begin
                held_bytes = {held_bytes[15:8], b};
            end
            group_fill = group_fill + 2'd1;
        end
        else
        begin
            held = int'(group_fill) + 1;
            b0 = (group_fill == 2'd0) ? b : held_bytes[15:8];
            b1 = (group_fill == 2'd0) ? 8'h00 : ((group_fill == 2'd1) ? b : held_bytes[7:0]);
            b2 = (group_fill == 2'd2) ? b : 8'h00;
            syms[0] = symbol(b0[7:2]);
            syms[1] = symbol({b0[1:0], b1[7:4]});
            syms[2] = (held > 1) ? symbol({b1[3:0], b2[7:6]}) : CHAR_PAD;
            syms[3] = (held > 2) ? symbol(b2[5:0]) : CHAR_PAD;
            n = 0;
            for (int i = 0; i < 4; i++)
            begin
                chars[n] = syms[i];
                n++;
                column++;
                if (column >= WRAP_WIDTH)
                begin
                    chars[n] = CHAR_NEWLINE;
                    n++;
                    column = 0;
                end
            end
            held_bytes = 16'h0000;
            group_fill = 2'd0;
            if (last && column != 0)
            begin
                chars[n] = CHAR_NEWLINE;
                n++;
                column = 0;
            end
            for (int i = 0; i < n; i++)
            begin
                beat.ch = chars[i];
                beat.last = (i == n - 1);
                expected_chars.push_back(beat);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        char_beat_t want;
        if (!rst_n)
        begin
            held_bytes = 16'h0000;
            group_fill = 2'd0;
            column = 0;
            expected_chars.delete();
            backlog = 0;
            mismatches = 0;
            beat_index = 0;
        end
        else
        begin
            if (push && !full)
            begin
                encode_byte(data_byte, is_last);
            end
            if (pop && !empty)
            begin
                if (expected_chars.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("beat %0d: unexpected output char %h last %b",
                                 beat_index, out_char, run_last);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (want.ch !== out_char || want.last !== run_last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("beat %0d: expected char %h last %b, got char %h last %b",
                                     beat_index, want.ch, want.last, out_char, run_last);
                        end
                        mismatches++;
                    end
                end
                beat_index++;
            end
            backlog = expected_chars.size();
        end
    end

endmodule

FILE: test/tb_base64_line_encoder_unit.sv
// Testbench top for the base64 line encoder: clock, reset, byte streams, output stalls and verdict.
`timescale 1ns / 1ps

module tb_base64_line_encoder_unit;
    import b64le_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 126;
    localparam int DIRECTED_ITEMS = 24;
    localparam logic [8*DIRECTED_ITEMS-1:0] DIRECTED_BYTES = {
        8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
        8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h4D, 8'h61, 8'h6E, 8'hAA,
        8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55
    };
    localparam logic [DIRECTED_ITEMS-1:0] DIRECTED_LAST = 24'b1101_0100_1001_0010_0010_0001;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] data_byte;
    logic       is_last;
    logic       empty;
    logic       pop;
    logic [7:0] out_char;
    logic       run_last;

    int tx_idle_pct;
    int rx_idle_pct;
    int mismatches;
    int backlog;
    int random_sent;
    int stall_cycles;

    base64_line_encoder_unit #(
        .LINE_CHARS(LINE_CHARS_DEFAULT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .data_byte(data_byte),
        .is_last(is_last),
        .empty(empty),
        .pop(pop),
        .out_char(out_char),
        .run_last(run_last)
    );

    b64_stream_checker #(
        .LINE_CHARS(LINE_CHARS_DEFAULT)
    ) text_checker (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .data_byte(data_byte),
        .is_last(is_last),
        .empty(empty),
        .pop(pop),
        .out_char(out_char),
        .run_last(run_last),
        .mismatches(mismatches),
        .backlog(backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        bit done;
        done = 0;
        while (!done)
        begin
            @(negedge clk);
            push <= ($urandom_range(0, 99) >= tx_idle_pct);
            data_byte <= b;
            is_last <= last;
            @(posedge clk);
            done = push && !full;
        end
    endtask

    task automatic send_stream(input int len);
        for (int i = 0; i < len; i++)
        begin
            if (random_sent < RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 14;
                rx_idle_pct = 47;
            end
            else if (random_sent < 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 47;
                rx_idle_pct = 14;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
            random_sent++;
        end
    endtask

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int stream_len;
        rst_n = 1'b0;
        push = 1'b0;
        data_byte = 8'h00;
        is_last = 1'b0;
        tx_idle_pct = 14;
        rx_idle_pct = 47;
        random_sent = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ITEMS; i++)
        begin
            send_byte(DIRECTED_BYTES[8*(DIRECTED_ITEMS-1-i) +: 8],
                      DIRECTED_LAST[DIRECTED_ITEMS-1-i]);
        end

        send_stream(48);
        while (random_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                stream_len = $urandom_range(45, 70);
            end
            else
            begin
                stream_len = $urandom_range(1, 12);
            end
            if (stream_len > RANDOM_ITEMS - random_sent)
            begin
                stream_len = RANDOM_ITEMS - random_sent;
            end
            send_stream(stream_len);
        end

        @(negedge clk);
        push <= 1'b0;
        while (backlog != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/b64le_pkg.sv
sv/b64le_front.sv
sv/b64le_queue.sv
sv/b64le_back.sv
sv/base64_line_encoder_unit.sv
test/b64_stream_checker.sv
test/tb_base64_line_encoder_unit.sv
